// ===== rtl/bfa_pkg.sv =====
// Shared types and constants of the best-fit block allocator.
package bfa_pkg;

  localparam int unsigned SizeBits = 24;
  localparam int unsigned NeedBits = SizeBits + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LIMIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_HELD = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_SCAN,
    CMD_ALLOC_MARK,
    CMD_APPEND,
    CMD_FREE_MISS,
    CMD_FREE_LAST,
    CMD_FREE_MERGE,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_INS_WR
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_DONE
  } state_e;

  typedef struct packed {
    logic scan_done;
    logic is_alloc;
    logic found;
    logic split;
    logic hit;
    logic last;
    logic copy_done;
    logic shift_up;
  } sts_t;

endpackage

// ===== rtl/bfa_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface bfa_req_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [bfa_pkg::SizeBits-1:0]    request_size;
  logic [bfa_pkg::SizeBits-1:0]    free_address;

  modport source (output valid, action, request_size, free_address, input ready);
  modport sink   (input valid, action, request_size, free_address, output ready);
endinterface

interface bfa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [bfa_pkg::SizeBits-1:0]    user_address;
  logic [bfa_pkg::SizeBits-1:0]    heap_top;

  modport source (output valid, status, user_address, heap_top, input ready);
  modport sink   (input valid, status, user_address, heap_top, output ready);
endinterface

// ===== rtl/bfa_ctrl.sv =====
// Sequencing state machine of the allocator.
module bfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bfa_pkg::sts_t sts_i,
  output bfa_pkg::cmd_e cmd_o
);

  bfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfa_pkg::S_IDLE:     if (in_valid_i) state_d = bfa_pkg::S_SCAN;
      bfa_pkg::S_SCAN:     if (sts_i.scan_done) state_d = bfa_pkg::S_DECIDE;
      bfa_pkg::S_DECIDE: begin
        if (sts_i.is_alloc) begin
          state_d = (sts_i.found && sts_i.split) ? bfa_pkg::S_SHIFT_RD : bfa_pkg::S_DONE;
        end else begin
          state_d = (sts_i.hit && !sts_i.last) ? bfa_pkg::S_SHIFT_RD : bfa_pkg::S_DONE;
        end
      end
      bfa_pkg::S_SHIFT_RD: begin
        if (sts_i.copy_done) begin
          state_d = sts_i.shift_up ? bfa_pkg::S_INS : bfa_pkg::S_DONE;
        end else begin
          state_d = bfa_pkg::S_SHIFT_WR;
        end
      end
      bfa_pkg::S_SHIFT_WR: state_d = bfa_pkg::S_SHIFT_RD;
      bfa_pkg::S_INS:      state_d = bfa_pkg::S_DONE;
      bfa_pkg::S_DONE:     if (out_ready_i) state_d = bfa_pkg::S_IDLE;
      default:             state_d = bfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = bfa_pkg::CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      bfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = bfa_pkg::CMD_START;
      end
      bfa_pkg::S_SCAN:   cmd_o = bfa_pkg::CMD_SCAN;
      bfa_pkg::S_DECIDE: begin
        if (sts_i.is_alloc) begin
          cmd_o = sts_i.found ? bfa_pkg::CMD_ALLOC_MARK : bfa_pkg::CMD_APPEND;
        end else if (!sts_i.hit) begin
          cmd_o = bfa_pkg::CMD_FREE_MISS;
        end else begin
          cmd_o = sts_i.last ? bfa_pkg::CMD_FREE_LAST : bfa_pkg::CMD_FREE_MERGE;
        end
      end
      bfa_pkg::S_SHIFT_RD: if (!sts_i.copy_done) cmd_o = bfa_pkg::CMD_SHIFT_RD;
      bfa_pkg::S_SHIFT_WR: cmd_o = bfa_pkg::CMD_SHIFT_WR;
      bfa_pkg::S_INS:      cmd_o = bfa_pkg::CMD_INS_WR;
      bfa_pkg::S_DONE:     out_valid_o = 1'b1;
      default:             cmd_o = bfa_pkg::CMD_NONE;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("response dropped");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == bfa_pkg::CMD_START) |=> (state_q == bfa_pkg::S_SCAN))
    else $error("start did not scan");

endmodule

// ===== rtl/bfa_datapath.sv =====
// Block table memory, scan registers, heap top and result registers.
module bfa_datapath #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfa_pkg::cmd_e                   cmd_i,
  output bfa_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [bfa_pkg::SizeBits-1:0]    cfg_wdata_i,
  input  logic                            action_i,
  input  logic [bfa_pkg::SizeBits-1:0]    request_size_i,
  input  logic [bfa_pkg::SizeBits-1:0]    free_address_i,
  output logic [1:0]                      status_o,
  output logic [bfa_pkg::SizeBits-1:0]    user_address_o,
  output logic [bfa_pkg::SizeBits-1:0]    heap_top_o
);

  localparam int unsigned SW = bfa_pkg::SizeBits;
  localparam int unsigned NW = bfa_pkg::NeedBits;
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [NW-1:0] Hdr  = NW'(HEADER_BYTES);
  localparam logic [CW-1:0] MaxC = CW'(MAX_BLOCKS);

  logic [SW:0] mem_q [MAX_BLOCKS];
  logic [SW:0] rd_q;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  logic [SW:0]   wd;

  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] heap_end_q, heap_end_d;
  logic [SW-1:0] limit_q;
  logic          alloc_q, alloc_d;
  logic [NW-1:0] need_q, need_d;
  logic [SW-1:0] faddr_q, faddr_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] pos_q, pos_d;
  logic          pend_q, pend_d;
  logic [NW-1:0] acc_q, acc_d;
  logic          found_q, found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [SW-1:0] best_size_q, best_size_d;
  logic [SW-1:0] best_addr_q, best_addr_d;
  logic          prev_occ_q, prev_occ_d;
  logic [SW-1:0] prev_size_q, prev_size_d;
  logic          hit_q, hit_d;
  logic          just_hit_q, just_hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [SW-1:0] hit_size_q, hit_size_d;
  logic          hp_occ_q, hp_occ_d;
  logic [SW-1:0] hp_size_q, hp_size_d;
  logic          nx_occ_q, nx_occ_d;
  logic [SW-1:0] nx_size_q, nx_size_d;
  logic [IW-1:0] src_q, src_d, dst_q, dst_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          up_q, up_d;
  logic [SW-1:0] rest_q, rest_d;
  logic [1:0]    status_q, status_d;
  logic [SW-1:0] user_q, user_d;

  logic          e_occ;
  logic [SW-1:0] e_size;
  logic [NW-1:0] diff;
  logic          split;
  logic          last;
  logic          mp, mn;
  logic [CW-1:0] hit_c;
  logic [NW:0]   top_sum;
  logic [CW-1:0] tmp_c;

  assign e_occ  = rd_q[SW];
  assign e_size = rd_q[SW-1:0];
  assign diff   = {1'b0, best_size_q} - need_q;
  assign split  = found_q && (diff > Hdr) && (count_q < MaxC);
  assign hit_c  = CW'(hit_idx_q);
  assign last   = (hit_c + CW'(1)) == count_q;
  assign mp     = (hit_idx_q != '0) && !hp_occ_q;
  assign mn     = !nx_occ_q;
  assign top_sum = {1'b0, NW'(heap_end_q)} + {1'b0, need_q};

  always_comb begin
    sts_o.scan_done = !pend_q && (idx_q == count_q);
    sts_o.is_alloc  = alloc_q;
    sts_o.found     = found_q;
    sts_o.split     = split;
    sts_o.hit       = hit_q;
    sts_o.last      = last;
    sts_o.copy_done = (rem_q == '0);
    sts_o.shift_up  = up_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    count_d = count_q;       heap_end_d = heap_end_q;
    alloc_d = alloc_q;       need_d = need_q;         faddr_d = faddr_q;
    idx_d = idx_q;           pos_d = pos_q;           pend_d = pend_q;
    acc_d = acc_q;           found_d = found_q;
    best_idx_d = best_idx_q; best_size_d = best_size_q; best_addr_d = best_addr_q;
    prev_occ_d = prev_occ_q; prev_size_d = prev_size_q;
    hit_d = hit_q;           just_hit_d = just_hit_q; hit_idx_d = hit_idx_q;
    hit_size_d = hit_size_q; hp_occ_d = hp_occ_q;     hp_size_d = hp_size_q;
    nx_occ_d = nx_occ_q;     nx_size_d = nx_size_q;
    src_d = src_q;           dst_d = dst_q;           rem_d = rem_q;
    up_d = up_q;             rest_d = rest_q;
    status_d = status_q;     user_d = user_q;
    rd_addr = idx_q[IW-1:0];
    we = 1'b0;
    wa = '0;
    wd = '0;
    tmp_c = '0;
    case (cmd_i)
      bfa_pkg::CMD_START: begin
        alloc_d  = (action_i == bfa_pkg::ACT_ALLOC);
        need_d   = {1'b0, request_size_i} + Hdr;
        faddr_d  = free_address_i;
        idx_d    = '0;
        pos_d    = '0;
        pend_d   = 1'b0;
        acc_d    = '0;
        found_d  = 1'b0;
        hit_d    = 1'b0;
        just_hit_d = 1'b0;
        rem_d    = '0;
        up_d     = 1'b0;
        status_d = bfa_pkg::ST_OK;
        user_d   = '0;
      end
      bfa_pkg::CMD_SCAN: begin
        pend_d = (idx_q != count_q);
        if (idx_q != count_q) idx_d = idx_q + CW'(1);
        if (pend_q) begin
          pos_d = pos_q + IW'(1);
          acc_d = acc_q + NW'(e_size);
          prev_occ_d  = e_occ;
          prev_size_d = e_size;
          if (alloc_q) begin
            if (!e_occ && (NW'(e_size) >= need_q) && (!found_q || e_size < best_size_q)) begin
              found_d     = 1'b1;
              best_idx_d  = pos_q;
              best_size_d = e_size;
              best_addr_d = acc_q[SW-1:0];
            end
          end else begin
            just_hit_d = 1'b0;
            if (just_hit_q) begin
              nx_occ_d  = e_occ;
              nx_size_d = e_size;
            end
            if (!hit_q && e_occ && ({1'b0, acc_q} + {1'b0, Hdr}) == (NW + 1)'(faddr_q)) begin
              hit_d      = 1'b1;
              just_hit_d = 1'b1;
              hit_idx_d  = pos_q;
              hit_size_d = e_size;
              hp_occ_d   = prev_occ_q;
              hp_size_d  = prev_size_q;
            end
          end
        end
      end
      bfa_pkg::CMD_ALLOC_MARK: begin
        we = 1'b1;
        wa = best_idx_q;
        wd = {1'b1, split ? need_q[SW-1:0] : best_size_q};
        user_d = best_addr_q + SW'(HEADER_BYTES);
        if (split) begin
          rest_d = best_size_q - need_q[SW-1:0];
          up_d   = 1'b1;
          tmp_c  = count_q - CW'(1);
          src_d  = tmp_c[IW-1:0];
          dst_d  = count_q[IW-1:0];
          rem_d  = count_q - (CW'(best_idx_q) + CW'(1));
        end
      end
      bfa_pkg::CMD_APPEND: begin
        if (top_sum > (NW + 1)'(limit_q)) begin
          status_d = bfa_pkg::ST_LIMIT;
        end else if (count_q == MaxC) begin
          status_d = bfa_pkg::ST_FULL;
        end else begin
          we = 1'b1;
          wa = count_q[IW-1:0];
          wd = {1'b1, need_q[SW-1:0]};
          user_d     = heap_end_q + SW'(HEADER_BYTES);
          heap_end_d = top_sum[SW-1:0];
          count_d    = count_q + CW'(1);
        end
      end
      bfa_pkg::CMD_FREE_MISS: status_d = bfa_pkg::ST_NOT_HELD;
      bfa_pkg::CMD_FREE_LAST: begin
        heap_end_d = heap_end_q - hit_size_q - (mp ? hp_size_q : '0);
        count_d    = count_q - CW'(1) - CW'(mp);
      end
      bfa_pkg::CMD_FREE_MERGE: begin
        we = 1'b1;
        wa = hit_idx_q - IW'(mp);
        wd = {1'b0, (mp ? hp_size_q : '0) + hit_size_q + (mn ? nx_size_q : '0)};
        count_d = count_q - CW'(mp) - CW'(mn);
        tmp_c   = hit_c + CW'(1) + CW'(mn);
        src_d   = tmp_c[IW-1:0];
        dst_d   = hit_idx_q - IW'(mp) + IW'(1);
        rem_d   = count_q - hit_c - CW'(1) - CW'(mn);
        up_d    = 1'b0;
      end
      bfa_pkg::CMD_SHIFT_RD: rd_addr = src_q;
      bfa_pkg::CMD_SHIFT_WR: begin
        we = 1'b1;
        wa = dst_q;
        wd = rd_q;
        rem_d = rem_q - CW'(1);
        src_d = up_q ? src_q - IW'(1) : src_q + IW'(1);
        dst_d = up_q ? dst_q - IW'(1) : dst_q + IW'(1);
      end
      bfa_pkg::CMD_INS_WR: begin
        we = 1'b1;
        wa = best_idx_q + IW'(1);
        wd = {1'b0, rest_q};
        count_d = count_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      heap_end_q <= '0;
      limit_q    <= '1;
      pend_q     <= 1'b0;
      idx_q      <= '0;
      rem_q      <= '0;
      up_q       <= 1'b0;
      alloc_q    <= 1'b0;
      found_q    <= 1'b0;
      hit_q      <= 1'b0;
      just_hit_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      heap_end_q <= heap_end_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      pend_q     <= pend_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      up_q       <= up_d;
      alloc_q    <= alloc_d;
      found_q    <= found_d;
      hit_q      <= hit_d;
      just_hit_q <= just_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d;           faddr_q <= faddr_d;
    pos_q <= pos_d;             acc_q <= acc_d;
    best_idx_q <= best_idx_d;   best_size_q <= best_size_d; best_addr_q <= best_addr_d;
    prev_occ_q <= prev_occ_d;   prev_size_q <= prev_size_d;
    hit_idx_q <= hit_idx_d;     hit_size_q <= hit_size_d;
    hp_occ_q <= hp_occ_d;       hp_size_q <= hp_size_d;
    nx_occ_q <= nx_occ_d;       nx_size_q <= nx_size_d;
    src_q <= src_d;             dst_q <= dst_d;
    rest_q <= rest_d;
    status_q <= status_d;       user_q <= user_d;
  end

  assign status_o       = status_q;
  assign user_address_o = user_q;
  assign heap_top_o     = heap_end_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxC) else $error("block count overflow");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == bfa_pkg::CMD_INS_WR) |-> (count_q < MaxC)) else $error("insert into full table");
  a_copy_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == bfa_pkg::CMD_SHIFT_WR) |-> ($past(cmd_i) == bfa_pkg::CMD_SHIFT_RD))
    else $error("copy write without read");

endmodule

// ===== rtl/best_fit_block_allocator.sv =====
// Best-fit heap block allocator: top level joining controller and datapath.
// One transaction at a time. An item scans the N-entry block table through the table
// memory and decides; when a split inserts or a merging free removes entries, each entry
// moved takes a read step and a write step. The response then waits in its register
// until taken, and the next request is accepted after that.
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfa_pkg::SizeBits-1:0]  cfg_wdata_i,
  bfa_req_if.sink                       in_i,
  bfa_rsp_if.source                     out_o
);

  bfa_pkg::cmd_e cmd;
  bfa_pkg::sts_t sts;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfa_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (in_i.action),
    .request_size_i (in_i.request_size),
    .free_address_i (in_i.free_address),
    .status_o       (out_o.status),
    .user_address_o (out_o.user_address),
    .heap_top_o     (out_o.heap_top)
  );

endmodule
